### rtl/core/soa_pkg.sv
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types and constants of the slab object allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package soa_pkg;

    localparam int MAX_SLABS_DEF    = 64;
    localparam int SIZE_CLASSES_DEF = 7;
    localparam int HEADER_BYTES_DEF = 40;

    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int MAP_BITS   = 128;
    localparam int MIN_SHIFT  = 5;
    localparam int GROUPS     = 8;
    localparam int GROUP_BITS = MAP_BITS / GROUPS;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_IGNORED  = 3'd1;
    localparam logic [2:0] ST_TOO_BIG  = 3'd2;
    localparam logic [2:0] ST_EXHAUST  = 3'd3;
    localparam logic [2:0] ST_BAD_FREE = 3'd4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [15:0] CLASS_BYTES [7] = '{
        16'd32, 16'd64, 16'd128, 16'd256, 16'd512, 16'd1024, 16'd2048
    };

    typedef struct packed {
        logic       hit;
        logic [6:0] slot;
    } soa_find_t;

endpackage

`default_nettype wire

### rtl/core/slab_object_allocator_top.sv
// ----------------------------------------------------------------------------
// slab_object_allocator_top
// Slab allocator with power-of-two size classes and per-slab slot maps.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate that takes the head slab of
// its class passes through check and table read, load, two-step slot search,
// update and result load; an allocate that opens a new slab skips the load,
// and a free that reads the slab table in its check then loads, updates and
// loads the result. A request that is rejected at once goes from its check
// straight to the result load. The input takes the next request the cycle
// after the result is loaded. The result load waits while an earlier result
// still waits in the output register. These steps are shaped by the
// single-port slab table, with its registered read and write-back, and by
// the two-step slot search. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module slab_object_allocator_top #(
    parameter int MAX_SLABS    = soa_pkg::MAX_SLABS_DEF,
    parameter int SIZE_CLASSES = soa_pkg::SIZE_CLASSES_DEF,
    parameter int HEADER_BYTES = soa_pkg::HEADER_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        in_valid,
    output wire logic        in_stall,
    input  wire logic        req_type,
    input  wire logic [15:0] alloc_size,
    input  wire logic [31:0] free_addr,
    output wire logic        out_valid,
    input  wire logic        out_stall,
    output wire logic [31:0] obj_addr,
    output wire logic [2:0]  status
);
    import soa_pkg::*;

    localparam int SW = $clog2(MAX_SLABS + 1);
    localparam int AW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
    localparam logic [SW-1:0] NO_SLAB = SW'(MAX_SLABS);
    localparam logic [11:0]   HDR     = 12'(HEADER_BYTES);
    localparam logic [11:0]   SPAN    = 12'(PAGE_BYTES - HEADER_BYTES);

    typedef struct packed {
        logic [MAP_BITS-1:0] map;
        logic [2:0]          cls;
        logic [7:0]          cnt;
        logic [SW-1:0]       link;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_ACHK, S_ALOAD, S_FIND, S_AEXEC, S_FCHK, S_FLOAD, S_FEXEC, S_DONE
    } state_t;

    state_t        state_reg;
    logic [31:0]   heap_base_reg;
    logic [SW-1:0] head_reg [SIZE_CLASSES];
    logic [SW-1:0] opened_reg;
    logic [15:0]   size_reg;
    logic [31:0]   addr_reg;
    logic [MAP_BITS-1:0] map_reg;
    logic [2:0]    cls_reg;
    logic [7:0]    cnt_reg;
    logic [SW-1:0] link_reg;
    logic [SW-1:0] slab_reg;
    logic [11:0]   inpage_reg;
    logic [31:0]   res_addr_reg;
    logic [2:0]    res_status_reg;
    logic          out_valid_reg;
    logic [31:0]   obj_addr_reg;
    logic [2:0]    status_reg;

    entry_t        mem [MAX_SLABS];
    entry_t        rd_data_reg;
    logic          mem_re;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    entry_t        mem_wdata;

    soa_find_t     find;
    logic          find_start;

    function automatic logic [7:0] cap_of(input logic [2:0] cls);
        logic [11:0] sh;
        sh = SPAN >> (MIN_SHIFT + int'(cls));
        return (sh > 12'(MAP_BITS)) ? 8'(MAP_BITS) : sh[7:0];
    endfunction

    // Size to class lookup.
    logic [2:0] size_cls;
    logic       size_cls_ok;
    always_comb
    begin
        size_cls    = 3'd0;
        size_cls_ok = 1'b0;
        for (int i = SIZE_CLASSES - 1; i >= 0; i--)
        begin
            if (size_reg <= CLASS_BYTES[i])
            begin
                size_cls    = 3'(i);
                size_cls_ok = 1'b1;
            end
        end
    end

    logic [7:0]          cap_c;
    logic [MAP_BITS-1:0] cap_mask;
    logic [SW-1:0]       head_c;
    logic                exhausted;
    logic [32:0]         off_c;
    logic [11:0]         slot_c;
    logic [19:0]         page_c;
    logic [31:0]         alloc_addr_c;
    logic [7:0]          cnt_dec;
    logic [MAP_BITS-1:0] map_clr;
    logic [MAP_BITS-1:0] map_set;

    always_comb
    begin
        cap_c = cap_of(state_reg == S_ACHK ? size_cls : cls_reg);
        for (int i = 0; i < MAP_BITS; i++)
        begin
            cap_mask[i] = (8'(i) < cap_c);
        end
        head_c    = head_reg[size_cls];
        exhausted = (opened_reg == NO_SLAB) ||
                    ((21'(heap_base_reg[31:12]) + 21'(opened_reg)) > 21'h0FFFFF);
        off_c     = {1'b0, addr_reg} - {1'b0, heap_base_reg[31:12], 12'd0};
        slot_c    = (inpage_reg - HDR) >> (MIN_SHIFT + int'(cls_reg));
        page_c    = heap_base_reg[31:12] + 20'(slab_reg);
        alloc_addr_c = {page_c, 12'd0} + 32'(HDR) +
                       (32'(find.slot) << (MIN_SHIFT + int'(cls_reg)));
        cnt_dec   = cnt_reg - 8'd1;
        map_clr   = map_reg & ~(MAP_BITS'(1) << find.slot);
        map_set   = map_reg | (MAP_BITS'(1) << slot_c[6:0]);
    end

    logic free_ok;
    assign free_ok = (slot_c < 12'(cap_c)) && !map_reg[slot_c[6:0]];

    // Slab table control.
    always_comb
    begin
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = slab_reg[AW-1:0];
        mem_wdata = '{map: map_reg, cls: cls_reg, cnt: cnt_reg, link: link_reg};
        find_start = (state_reg == S_FIND);
        case (state_reg)
            S_ACHK:
            begin
                mem_re   = 1'b1;
                mem_addr = head_c[AW-1:0];
            end
            S_FCHK:
            begin
                mem_re   = 1'b1;
                mem_addr = off_c[PAGE_SHIFT +: AW];
            end
            S_AEXEC:
            begin
                mem_we = find.hit;
                mem_wdata = '{map: map_clr, cls: cls_reg, cnt: cnt_dec,
                              link: (cnt_dec == 8'd0) ? NO_SLAB : link_reg};
            end
            S_FEXEC:
            begin
                mem_we = free_ok;
                mem_wdata = '{map: map_set, cls: cls_reg, cnt: cnt_reg + 8'd1,
                              link: (cnt_reg == 8'd0) ? head_reg[cls_reg] : link_reg};
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    soa_slot_find u_find (
        .clk    (clk),
        .start  (find_start),
        .map    (map_reg),
        .result (find)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            heap_base_reg <= 32'd0;
            opened_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SIZE_CLASSES; i++)
            begin
                head_reg[i] <= NO_SLAB;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                heap_base_reg <= cfg_wr_data;
            end
            // The result register is reloaded in S_DONE instead of cleared.
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        size_reg  <= alloc_size;
                        addr_reg  <= free_addr;
                        state_reg <= (req_type == REQ_FREE) ? S_FCHK : S_ACHK;
                    end
                end
                S_ACHK:
                begin
                    res_addr_reg <= 32'd0;
                    cls_reg      <= size_cls;
                    if (size_reg == 16'd0)
                    begin
                        res_status_reg <= ST_IGNORED;
                        state_reg      <= S_DONE;
                    end
                    else if (!size_cls_ok)
                    begin
                        res_status_reg <= ST_TOO_BIG;
                        state_reg      <= S_DONE;
                    end
                    else if (head_c != NO_SLAB)
                    begin
                        slab_reg  <= head_c;
                        state_reg <= S_ALOAD;
                    end
                    else if (exhausted)
                    begin
                        res_status_reg <= ST_EXHAUST;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        // A fresh slab starts with every usable slot free.
                        slab_reg   <= opened_reg;
                        map_reg    <= cap_mask;
                        cnt_reg    <= cap_c;
                        link_reg   <= NO_SLAB;
                        head_reg[size_cls] <= opened_reg;
                        opened_reg <= opened_reg + SW'(1);
                        state_reg  <= S_FIND;
                    end
                end
                S_ALOAD:
                begin
                    map_reg   <= rd_data_reg.map;
                    cnt_reg   <= rd_data_reg.cnt;
                    link_reg  <= rd_data_reg.link;
                    state_reg <= S_FIND;
                end
                S_FIND:
                begin
                    state_reg <= S_AEXEC;
                end
                S_AEXEC:
                begin
                    state_reg <= S_DONE;
                    if (!find.hit)
                    begin
                        res_status_reg <= ST_EXHAUST;
                    end
                    else
                    begin
                        res_status_reg <= ST_OK;
                        res_addr_reg   <= alloc_addr_c;
                        if (cnt_dec == 8'd0)
                        begin
                            head_reg[cls_reg] <= link_reg;
                        end
                    end
                end
                S_FCHK:
                begin
                    res_addr_reg   <= 32'd0;
                    slab_reg       <= SW'(off_c[31:12]);
                    inpage_reg     <= off_c[11:0];
                    if (addr_reg == 32'd0)
                    begin
                        res_status_reg <= ST_IGNORED;
                        state_reg      <= S_DONE;
                    end
                    else if (!off_c[32] && (off_c[31:12] < 20'(opened_reg)) &&
                             (off_c[11:0] >= HDR))
                    begin
                        res_status_reg <= ST_BAD_FREE;
                        state_reg      <= S_FLOAD;
                    end
                    else
                    begin
                        res_status_reg <= ST_BAD_FREE;
                        state_reg      <= S_DONE;
                    end
                end
                S_FLOAD:
                begin
                    map_reg   <= rd_data_reg.map;
                    cls_reg   <= rd_data_reg.cls;
                    cnt_reg   <= rd_data_reg.cnt;
                    link_reg  <= rd_data_reg.link;
                    state_reg <= S_FEXEC;
                end
                S_FEXEC:
                begin
                    state_reg <= S_DONE;
                    if (free_ok)
                    begin
                        res_status_reg <= ST_OK;
                        // A full slab rejoins its partial list at the head.
                        if (cnt_reg == 8'd0)
                        begin
                            head_reg[cls_reg] <= slab_reg;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        obj_addr_reg  <= res_addr_reg;
                        status_reg    <= res_status_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign obj_addr  = obj_addr_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

### rtl/core/soa_slot_find.sv
// ----------------------------------------------------------------------------
// soa_slot_find
// Two-step search for the lowest set bit of a 128-bit slot map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module soa_slot_find (
    input  wire logic                      clk,
    input  wire logic                      start,
    input  wire logic [127:0]              map,
    output soa_pkg::soa_find_t             result
);
    import soa_pkg::*;

    logic [GROUPS-1:0] grp_hit_reg;
    logic [3:0]        grp_idx_reg [GROUPS];
    logic [GROUPS-1:0] grp_hit_next;
    logic [3:0]        grp_idx_next [GROUPS];

    // First step: each 16-bit group finds its own lowest free slot.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_hit_next[g] = |map[g*GROUP_BITS +: GROUP_BITS];
            grp_idx_next[g] = 4'd0;
            for (int b = GROUP_BITS - 1; b >= 0; b--)
            begin
                if (map[g*GROUP_BITS + b])
                begin
                    grp_idx_next[g] = 4'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            grp_hit_reg <= grp_hit_next;
            for (int g = 0; g < GROUPS; g++)
            begin
                grp_idx_reg[g] <= grp_idx_next[g];
            end
        end
    end

    // Second step: the lowest group with a free slot wins.
    always_comb
    begin
        result.hit  = |grp_hit_reg;
        result.slot = 7'd0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_hit_reg[g])
            begin
                result.slot = {3'(g), grp_idx_reg[g]};
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/soa_checker.sv
// ----------------------------------------------------------------------------
// soa_checker
// Port-level checks on the slab object allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module soa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] obj_addr,
    input wire logic [2:0]  status
);
    import soa_pkg::*;

    // A result that waits keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(obj_addr) && $stable(status))
        else $error("result changed while stalled");

    // Only a successful transfer carries an address.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> obj_addr == 32'd0)
        else $error("address given with a failing status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_IGNORED) ||
            (status == ST_TOO_BIG) || (status == ST_EXHAUST) || (status == ST_BAD_FREE))
        else $error("status code out of range");

    // One request at a time: after a transfer the input is busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

endmodule

bind slab_object_allocator_top soa_checker u_soa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .obj_addr  (obj_addr),
    .status    (status)
);

`default_nettype wire

### tb/tb_slab_object_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_slab_object_allocator_top
// Self-checking bench for the slab object allocator. A queue of requests
// feeds a stalling driver. A monitor compares every result transfer, in
// order, with the prediction made when the request was queued. Three heap
// bases are used: the top page, zero and a middle address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_slab_object_allocator_top;
    import soa_pkg::*;

    typedef struct {
        logic        kind;
        logic [15:0] size;
        logic [31:0] addr;
    } request_t;

    typedef struct {
        logic [31:0] addr;
        logic [2:0]  st;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [15:0] alloc_size = '0;
    logic [31:0] free_addr = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] obj_addr;
    logic [2:0]  status;

    slab_object_allocator_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .alloc_size(alloc_size), .free_addr(free_addr),
        .out_valid(out_valid), .out_stall(out_stall),
        .obj_addr(obj_addr), .status(status)
    );

    // Allocator state as predicted by the bench.
    logic [31:0]  heap_reg;
    logic [127:0] free_map [64];
    logic [2:0]   slab_cls [64];
    logic [7:0]   slab_avail [64];
    logic [6:0]   slab_next [64];
    logic [6:0]   list_head [7];
    logic [6:0]   opened;

    request_t    pending_reqs [$];
    reply_t      awaited_replies [$];
    logic [31:0] live_objs [$];
    logic [31:0] freed_objs [$];

    int  mismatches = 0;
    int  st_seen [5];
    bit  accepted_in = 1'b0;
    bit  quiet_tx = 1'b0;
    bit  quiet_rx = 1'b0;
    bit  hold_request = 1'b0;
    int  tx_gap = 0;
    int  rx_hold = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results outstanding", awaited_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned class_cap(int c);
        int unsigned cp;
        cp = (PAGE_BYTES - 40) / CLASS_BYTES[c];
        return (cp > 128) ? 128 : cp;
    endfunction

    function automatic logic [32:0] slab_page(logic [6:0] n);
        return {1'b0, heap_reg & 32'hFFFF_F000} + ({26'd0, n} << 12);
    endfunction

    task automatic predict_alloc(input logic [15:0] sz, output reply_t r);
        int c;
        int unsigned cp;
        int s;
        logic [6:0] sl;
        c = 7;
        r.addr = '0;
        if (sz == 0)
        begin
            r.st = ST_IGNORED;
            return;
        end
        for (int i = 6; i >= 0; i--)
            if (sz <= CLASS_BYTES[i]) c = i;
        if (c == 7)
        begin
            r.st = ST_TOO_BIG;
            return;
        end
        cp = class_cap(c);
        sl = list_head[c];
        if (sl >= 64)
        begin
            if (opened >= 64 || slab_page(opened) + 33'd4096 > 33'h1_0000_0000)
            begin
                r.st = ST_EXHAUST;
                return;
            end
            sl = opened;
            opened = opened + 1;
            free_map[sl] = '0;
            for (int i = 0; i < cp; i++) free_map[sl][i] = 1'b1;
            slab_cls[sl] = c[2:0];
            slab_avail[sl] = cp[7:0];
            slab_next[sl] = 7'd64;
            list_head[c] = sl;
        end
        s = -1;
        for (int i = cp - 1; i >= 0; i--)
            if (free_map[sl][i]) s = i;
        if (s < 0)
        begin
            r.st = ST_EXHAUST;
            return;
        end
        free_map[sl][s] = 1'b0;
        slab_avail[sl] = slab_avail[sl] - 1;
        if (slab_avail[sl] == 0)
        begin
            list_head[c] = slab_next[sl];
            slab_next[sl] = 7'd64;
        end
        r.addr = 32'(slab_page(sl) + 33'd40 + 33'(s * CLASS_BYTES[c]));
        r.st = ST_OK;
    endtask

    task automatic predict_free(input logic [31:0] a, output reply_t r);
        logic [32:0] base;
        logic [32:0] off;
        logic [6:0]  sl;
        int unsigned inpage;
        int unsigned s;
        int c;
        r.addr = '0;
        r.st = ST_BAD_FREE;
        if (a == 0)
        begin
            r.st = ST_IGNORED;
            return;
        end
        base = slab_page(0);
        if ({1'b0, a} < base) return;
        off = {1'b0, a} - base;
        if ((off >> 12) >= opened) return;
        sl = off[18:12];
        inpage = off[11:0];
        if (inpage < 40) return;
        c = slab_cls[sl];
        s = (inpage - 40) / CLASS_BYTES[c];
        if (s >= class_cap(c) || free_map[sl][s]) return;
        free_map[sl][s] = 1'b1;
        if (slab_avail[sl] == 0)
        begin
            slab_next[sl] = list_head[c];
            list_head[c] = sl;
        end
        slab_avail[sl] = slab_avail[sl] + 1;
        r.st = ST_OK;
    endtask

    // Queues a request together with its predicted result.
    task automatic queue_request(input logic k, input logic [15:0] sz, input logic [31:0] a);
        request_t q;
        reply_t r;
        q.kind = k;
        q.size = sz;
        q.addr = a;
        if (k == REQ_ALLOC)
        begin
            predict_alloc(sz, r);
            if (r.st == ST_OK) live_objs.push_back(r.addr);
        end
        else
        begin
            predict_free(a, r);
            if (r.st == ST_OK) freed_objs.push_back(a);
            if (freed_objs.size() > 16) void'(freed_objs.pop_front());
        end
        pending_reqs.push_back(q);
        awaited_replies.push_back(r);
    endtask

    task automatic drain_and_write(input logic [31:0] v);
        wait (pending_reqs.size() == 0 && awaited_replies.size() == 0);
        repeat (20) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        heap_reg = v;
    endtask

    task automatic random_requests(input int n);
        int r;
        int idx;
        int c;
        logic [31:0] a;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55 || (r < 85 && live_objs.size() == 0))
            begin
                r = $urandom_range(0, 99);
                if (r < 3) queue_request(REQ_ALLOC, 16'd0, $urandom);
                else if (r < 8) queue_request(REQ_ALLOC, 16'($urandom_range(2049, 65535)), $urandom);
                else
                begin
                    c = $urandom_range(0, 6);
                    queue_request(REQ_ALLOC,
                        16'($urandom_range(c == 0 ? 1 : CLASS_BYTES[c - 1] + 1, CLASS_BYTES[c])),
                        $urandom);
                end
            end
            else if (r < 85)
            begin
                idx = $urandom_range(0, live_objs.size() - 1);
                a = live_objs[idx];
                live_objs.delete(idx);
                // Addresses inside an object free the same object.
                if ($urandom_range(0, 3) == 0) a = a + $urandom_range(0, 31);
                queue_request(REQ_FREE, 16'($urandom), a);
            end
            else if (r < 92 && freed_objs.size() > 0)
            begin
                queue_request(REQ_FREE, 16'($urandom),
                    freed_objs[$urandom_range(0, freed_objs.size() - 1)]);
            end
            else if (r < 96)
            begin
                queue_request(REQ_FREE, 16'($urandom), 32'($urandom_range(0, 1) ? $urandom
                    : (heap_reg & 32'hFFFF_F000) + $urandom_range(0, 70 * 4096)));
            end
            else
            begin
                queue_request(REQ_FREE, 16'($urandom), 32'd0);
            end
        end
    endtask

    // Sender: holds the payload while stalled, otherwise moves on.
    always @(negedge clk)
    begin
        request_t q;
        bit busy;
        bit v;
        busy = in_valid && !accepted_in;
        v = busy;
        if (in_valid && accepted_in) void'(pending_reqs.pop_front());
        if (!busy && rst_n)
        begin
            if ($urandom_range(0, 999) < 4) quiet_tx = !quiet_tx;
            if (tx_gap > 0)
            begin
                tx_gap--;
                v = 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                q = pending_reqs[0];
                req_type <= q.kind;
                alloc_size <= q.size;
                free_addr <= q.addr;
                v = 1'b1;
                if (!quiet_tx)
                    tx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 2);
            end
            else
            begin
                v = 1'b0;
            end
        end
        in_valid <= v;
    end

    // Receiver: random stalls, plus one long hold to back the block up.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            rx_hold = 400;
        end
        if ($urandom_range(0, 999) < 4) quiet_rx = !quiet_rx;
        if (rx_hold > 0)
        begin
            rx_hold--;
            out_stall <= 1'b1;
        end
        else if (!quiet_rx && $urandom_range(0, 99) < 30)
        begin
            rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: notes input transfers and checks every result transfer.
    always @(posedge clk)
    begin
        reply_t e;
        accepted_in <= in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result addr=%h status=%0d", obj_addr, status);
            end
            else
            begin
                e = awaited_replies.pop_front();
                if (status <= 4) st_seen[status]++;
                if (obj_addr !== e.addr || status !== e.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                                 e.addr, e.st, obj_addr, status);
                end
            end
        end
    end

    initial
    begin
        heap_reg = '0;
        opened = '0;
        for (int i = 0; i < 7; i++) list_head[i] = 7'd64;
        for (int i = 0; i < 64; i++) slab_next[i] = 7'd64;
        for (int i = 0; i < 5; i++) st_seen[i] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Top page of the address space: only one slab fits.
        drain_and_write(32'hFFFF_FFFF);
        queue_request(REQ_ALLOC, 16'd0, 32'hFFFF_FFFF);
        queue_request(REQ_ALLOC, 16'd2049, 32'd0);
        queue_request(REQ_ALLOC, 16'hFFFF, 32'd0);
        queue_request(REQ_ALLOC, 16'd2048, 32'd0);
        queue_request(REQ_ALLOC, 16'd2048, 32'd0);
        queue_request(REQ_ALLOC, 16'd1, 32'd0);
        queue_request(REQ_FREE, 16'hFFFF, 32'd0);
        queue_request(REQ_FREE, 16'd0, 32'hFFFF_F028);
        queue_request(REQ_FREE, 16'd0, 32'hFFFF_F028);
        queue_request(REQ_FREE, 16'd0, 32'hFFFF_F000);
        queue_request(REQ_FREE, 16'd0, 32'h0000_0010);
        queue_request(REQ_FREE, 16'd0, 32'hFFFF_FFFF);
        queue_request(REQ_ALLOC, 16'd1500, 32'd0);
        queue_request(REQ_FREE, 16'd0, 32'hFFFF_F7FF);

        drain_and_write(32'h0000_0000);
        live_objs.delete();
        freed_objs.delete();
        queue_request(REQ_ALLOC, 16'd32, 32'd0);
        queue_request(REQ_ALLOC, 16'd33, 32'd0);
        queue_request(REQ_FREE, 16'd0, 32'h0000_1028);
        queue_request(REQ_FREE, 16'd0, 32'h0000_2FFF);
        random_requests(640);

        drain_and_write(32'h4000_0ABC);
        live_objs.delete();
        freed_objs.delete();
        @(posedge clk);
        hold_request = 1'b1;
        random_requests(640);

        wait (pending_reqs.size() == 0 && awaited_replies.size() == 0);
        repeat (20) @(posedge clk);
        $display("covered three heap bases, %0d slabs opened; results ok=%0d ignored=%0d",
                 opened, st_seen[0], st_seen[1]);
        $display("too large=%0d exhausted=%0d invalid free=%0d, mismatches=%0d",
                 st_seen[2], st_seen[3], st_seen[4], mismatches);
        if (mismatches == 0 && awaited_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/soa_pkg.sv
rtl/core/soa_slot_find.sv
rtl/core/slab_object_allocator_top.sv
rtl/core/soa_checker.sv
tb/tb_slab_object_allocator_top.sv
